>>> sv/rfsc_pkg.sv
// Shared types and constants of the recency/frequency slot cache.
// No dependencies; imported by every module of the block but rfsc_ram.
package rfsc_pkg;

    localparam int LAYER_W  = 6;
    localparam int EXPERT_W = 8;
    localparam int SLOT_W   = 4;
    localparam int SLOTS    = 16;
    localparam int LAYERS   = 64;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 32;
    localparam int FRAC     = 24;
    localparam int MAP_AW   = LAYER_W + EXPERT_W;
    localparam int SLOT_AW  = LAYER_W + SLOT_W;
    localparam int MAP_DW   = SLOT_W + 1;
    localparam int DIV_W    = CNT_W + FRAC;
    localparam int DVS_W    = TIME_W + 1;
    localparam int REC_W    = FRAC + 1;
    localparam int SCORE_W  = DIV_W + 1;
    localparam int STEP_W   = 6;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 9;

    typedef enum logic [CFG_AW-1:0] {
        CFG_ENABLE  = 3'd0,
        CFG_LAYERS  = 3'd1,
        CFG_EXPERTS = 3'd2,
        CFG_SLOTS   = 3'd3,
        CFG_PREWARM = 3'd4
    } t_cfg_idx;

    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_FREE    = 3'd1;
    localparam logic [2:0] ST_EVICT   = 3'd2;
    localparam logic [2:0] ST_PREWARM = 3'd3;
    localparam logic [2:0] ST_IGNORE  = 3'd4;

    localparam logic OP_TOUCH   = 1'b0;
    localparam logic OP_PREWARM = 1'b1;

    typedef struct packed {
        logic                ok;
        logic                op;
        logic [LAYER_W-1:0]  layer;
        logic [EXPERT_W-1:0] expert;
        logic [SLOT_W-1:0]   last;
    } t_cmd;

    typedef struct packed {
        logic [2:0]          status;
        logic                was_loaded;
        logic [SLOT_W-1:0]   slot;
        logic [EXPERT_W-1:0] evicted;
    } t_result;

    typedef struct packed {
        logic [EXPERT_W-1:0] id;
        logic [TIME_W-1:0]   last_t;
        logic [TIME_W-1:0]   load_t;
        logic [CNT_W-1:0]    cnt;
    } t_slot_ent;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

>>> sv/recency_frequency_slot_cache.sv
// Top level of the recency/frequency slot cache of expert ids.
// Depends on rfsc_pkg, rfsc_front, rfsc_fifo and rfsc_back.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------
//  input   | i_in_valid / o_in_stall   | i_op, i_layer, i_expert
//  result  | o_out_valid / i_out_stall | o_status, o_was_loaded,
//          |                           | o_slot_index, o_evicted_expert
//  config  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Items go one at a time through the back end. An eviction scores every slot in
// use in turn, dividing with the shared one-bit-a-cycle divider where needed.
// After reset a clearing pass sweeps the expert map, the occupancy rows and the
// layer clocks; input is stalled meanwhile while configuration writes are taken
// as ever.
// A two-entry queue holds classified items so input transfers can proceed
// while the back end works or a result waits on a stalled output.
module recency_frequency_slot_cache (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rfsc_pkg::CFG_AW-1:0]    i_cfg_index,
    input  logic [rfsc_pkg::CFG_DW-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_op,
    input  logic [rfsc_pkg::LAYER_W-1:0]   i_layer,
    input  logic [rfsc_pkg::EXPERT_W-1:0]  i_expert,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_status,
    output logic                           o_was_loaded,
    output logic [rfsc_pkg::SLOT_W-1:0]    o_slot_index,
    output logic [rfsc_pkg::EXPERT_W-1:0]  o_evicted_expert
);
    import rfsc_pkg::*;

    logic       push, pop, q_full, q_valid;
    t_cmd       f_cmd, q_cmd;
    t_back_stat back_stat;
    t_result    res;

    // classify each transfer and hold configuration
    rfsc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_op(i_op), .i_layer(i_layer),
        .i_expert(i_expert), .i_q_full(q_full), .i_back(back_stat),
        .o_in_stall(o_in_stall), .o_push(push), .o_cmd(f_cmd));

    // decouple front from back
    rfsc_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_cmd(f_cmd),
        .i_pop(pop), .o_full(q_full), .o_valid(q_valid), .o_cmd(q_cmd));

    // carry out lookups, updates and evictions
    rfsc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid),
        .i_q_cmd(q_cmd), .o_q_pop(pop), .o_stat(back_stat),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_result(res));

    assign o_status         = res.status;
    assign o_was_loaded     = res.was_loaded;
    assign o_slot_index     = res.slot;
    assign o_evicted_expert = res.evicted;
endmodule

>>> sv/rfsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rfsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/rfsc_div.sv
// Shared restoring divider, one quotient bit per cycle, variable step count.
// Depends on rfsc_pkg.
module rfsc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rfsc_pkg::DIV_W-1:0]  i_dividend,
    input  logic [rfsc_pkg::DVS_W-1:0]  i_divisor,
    input  logic [rfsc_pkg::STEP_W-1:0] i_steps,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [rfsc_pkg::DIV_W-1:0]  o_quo
);
    import rfsc_pkg::*;

    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DIV_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DVS_W:0]    trial;
    logic              fits;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? DVS_W'(trial - {1'b0, r_dvs}) : DVS_W'(trial);
                r_quo <= {r_quo[DIV_W-2:0], fits};
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

>>> sv/rfsc_front.sv
// Front end: configuration registers, range checks and item classification.
// Depends on rfsc_pkg.
module rfsc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rfsc_pkg::CFG_AW-1:0]  i_cfg_index,
    input  logic [rfsc_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_op,
    input  logic [rfsc_pkg::LAYER_W-1:0] i_layer,
    input  logic [rfsc_pkg::EXPERT_W-1:0] i_expert,
    input  logic                         i_q_full,
    input  rfsc_pkg::t_back_stat         i_back,
    output logic                         o_in_stall,
    output logic                         o_push,
    output rfsc_pkg::t_cmd               o_cmd
);
    import rfsc_pkg::*;

    logic       r_enable;
    logic [6:0] r_layers;
    logic [8:0] r_experts;
    logic [4:0] r_slots;
    logic       r_prewarm;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b1;
            r_layers  <= 7'd64;
            r_experts <= 9'd256;
            r_slots   <= 5'd16;
            r_prewarm <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:  r_enable  <= i_cfg_data[0];
                CFG_LAYERS:  r_layers  <= i_cfg_data[6:0];
                CFG_EXPERTS: r_experts <= i_cfg_data;
                CFG_SLOTS:   r_slots   <= i_cfg_data[4:0];
                CFG_PREWARM: r_prewarm <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = i_q_full | i_back.clearing;
    assign o_push     = i_in_valid & ~o_in_stall;

    always_comb begin
        o_cmd.ok = r_enable && ({1'b0, i_layer} < r_layers)
                   && ({1'b0, i_expert} < r_experts)
                   && (i_op == OP_TOUCH || r_prewarm);
        o_cmd.op     = i_op;
        o_cmd.layer  = i_layer;
        o_cmd.expert = i_expert;
        // clamp the slot count to 1..SLOTS and keep the last index
        if (r_slots == 5'd0) begin
            o_cmd.last = '0;
        end else if (r_slots > 5'(SLOTS)) begin
            o_cmd.last = SLOT_W'(SLOTS - 1);
        end else begin
            o_cmd.last = SLOT_W'(r_slots - 5'd1);
        end
    end
endmodule

>>> sv/rfsc_fifo.sv
// Two-entry command queue between front and back.
// Depends on rfsc_pkg.
module rfsc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rfsc_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output rfsc_pkg::t_cmd o_cmd
);
    import rfsc_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_mem[r_rp];
endmodule

>>> sv/rfsc_back.sv
// Back end: clearing pass, tag lookup, hit update, fill, prewarm and score-based eviction.
// Depends on rfsc_pkg, rfsc_ram and rfsc_div.
module rfsc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  rfsc_pkg::t_cmd       i_q_cmd,
    output logic                 o_q_pop,
    output rfsc_pkg::t_back_stat o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rfsc_pkg::t_result    o_result
);
    import rfsc_pkg::*;

    typedef enum logic [13:0] {
        S_CLEAR = 14'h0001,
        S_IDLE  = 14'h0002,
        S_LOOK  = 14'h0004,
        S_HITWR = 14'h0008,
        S_SRD   = 14'h0010,
        S_SDATA = 14'h0020,
        S_RDIV  = 14'h0040,
        S_FSET  = 14'h0080,
        S_FDIV  = 14'h0100,
        S_CMP   = 14'h0200,
        S_EVMAP = 14'h0400,
        S_EVCHK = 14'h0800,
        S_INST  = 14'h1000,
        S_EMIT  = 14'h2000
    } t_state;

    t_state              r_state;
    logic [MAP_AW-1:0]   r_clr;
    t_cmd                r_cmd;
    t_result             r_res;
    t_result             r_out;
    logic                r_ov;
    logic [TIME_W-1:0]   r_now;
    logic [SLOTS-1:0]    r_vrow;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_cnt1;
    logic [SLOT_W-1:0]   r_idx;
    t_slot_ent           r_ent;
    logic [REC_W-1:0]    r_r;
    logic [DIV_W-1:0]    r_f;
    logic [SCORE_W-1:0]  r_best;
    logic [SLOT_W-1:0]   r_bidx;
    logic [EXPERT_W-1:0] r_bid;

    // memory ports
    logic                map_we, vld_we, clk_we, slot_we;
    logic [MAP_AW-1:0]   map_wa, map_ra;
    logic [MAP_DW-1:0]   map_wd, map_rd;
    logic [LAYER_W-1:0]  vld_wa, vld_ra, clk_wa, clk_ra;
    logic [SLOTS-1:0]    vld_wd, vld_rd;
    logic [TIME_W-1:0]   clk_wd, clk_rd;
    logic [SLOT_AW-1:0]  slot_wa, slot_ra;
    t_slot_ent           slot_wd, slot_rd;

    // divider
    logic                div_start, div_busy, div_done;
    logic [DIV_W-1:0]    div_dvd, div_q;
    logic [DVS_W-1:0]    div_dvs;
    logic [STEP_W-1:0]   div_steps;

    // lookup decode
    logic [TIME_W-1:0]   now1;
    logic [SLOT_W-1:0]   hs;
    logic                hit;
    logic                free_found;
    logic [SLOT_W-1:0]   free_idx;
    logic [TIME_W-1:0]   dt, age;
    logic [SCORE_W-1:0]  score;
    logic                take;
    logic                out_free;

    rfsc_ram #(.WIDTH(MAP_DW), .DEPTH(LAYERS << EXPERT_W)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_wa), .i_wdata(map_wd),
        .i_raddr(map_ra), .o_rdata(map_rd));
    rfsc_ram #(.WIDTH(SLOTS), .DEPTH(LAYERS)) u_vld (
        .i_clk(i_clk), .i_we(vld_we), .i_waddr(vld_wa), .i_wdata(vld_wd),
        .i_raddr(vld_ra), .o_rdata(vld_rd));
    rfsc_ram #(.WIDTH(TIME_W), .DEPTH(LAYERS)) u_clk (
        .i_clk(i_clk), .i_we(clk_we), .i_waddr(clk_wa), .i_wdata(clk_wd),
        .i_raddr(clk_ra), .o_rdata(clk_rd));
    rfsc_ram #(.WIDTH($bits(t_slot_ent)), .DEPTH(LAYERS * SLOTS)) u_slot (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_wa), .i_wdata(slot_wd),
        .i_raddr(slot_ra), .o_rdata(slot_rd));

    rfsc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(div_dvd), .i_divisor(div_dvs), .i_steps(div_steps),
        .o_busy(div_busy), .o_done(div_done), .o_quo(div_q));

    assign now1     = clk_rd + TIME_W'(1);
    assign hs       = map_rd[SLOT_W-1:0];
    assign hit      = map_rd[SLOT_W] & vld_rd[hs];
    assign dt       = r_now - r_ent.last_t;
    assign age      = r_now - r_ent.load_t;
    assign score    = SCORE_W'(r_r) + SCORE_W'(r_f);
    assign take     = (r_idx == '0) || (score < r_best);
    assign out_free = ~r_ov | ~i_out_stall;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!vld_rd[i] && (SLOT_W'(i) <= r_cmd.last)) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // memory and divider controls
    always_comb begin
        map_we  = 1'b0;
        vld_we  = 1'b0;
        clk_we  = 1'b0;
        slot_we = 1'b0;
        map_wa  = {r_cmd.layer, r_cmd.expert};
        map_wd  = {1'b1, r_slot};
        map_ra  = {i_q_cmd.layer, i_q_cmd.expert};
        vld_wa  = r_cmd.layer;
        vld_wd  = r_vrow | (SLOTS'(1) << r_slot);
        vld_ra  = i_q_cmd.layer;
        clk_wa  = r_cmd.layer;
        clk_wd  = r_now;
        clk_ra  = i_q_cmd.layer;
        slot_wa = {r_cmd.layer, r_slot};
        slot_wd = '{id: r_cmd.expert, last_t: r_now, load_t: r_now,
                    cnt: CNT_W'(r_cnt1)};
        slot_ra = {r_cmd.layer, r_idx};
        div_start = 1'b0;
        div_dvd   = {1'b1, {(DIV_W-1){1'b0}}};
        div_dvs   = {1'b0, dt} + DVS_W'(1);
        div_steps = STEP_W'(REC_W);
        unique case (r_state)
            S_CLEAR: begin
                map_we = 1'b1;
                map_wa = r_clr;
                map_wd = '0;
                vld_we = r_clr[MAP_AW-1:LAYER_W] == '0;
                vld_wa = r_clr[LAYER_W-1:0];
                vld_wd = '0;
                clk_we = vld_we;
                clk_wa = r_clr[LAYER_W-1:0];
                clk_wd = '0;
            end
            S_LOOK:  slot_ra = {r_cmd.layer, hs};
            S_HITWR: begin
                slot_we = 1'b1;
                slot_wd = slot_rd;
                slot_wd.last_t = r_now;
                if (slot_rd.cnt != '1) begin
                    slot_wd.cnt = slot_rd.cnt + CNT_W'(1);
                end
                clk_we = 1'b1;
            end
            S_SDATA: div_start = 1'b0;
            S_RDIV:  div_start = 1'b0;
            S_FSET: begin
                div_dvd   = {r_ent.cnt, {FRAC{1'b0}}};
                div_dvs   = {1'b0, age} + DVS_W'(1);
                div_steps = STEP_W'(DIV_W);
                div_start = (r_ent.cnt != '0) && (r_now > r_ent.load_t);
            end
            S_EVMAP: map_ra = {r_cmd.layer, r_bid};
            S_EVCHK: begin
                map_wa = {r_cmd.layer, r_bid};
                map_wd = {1'b0, map_rd[SLOT_W-1:0]};
                map_we = map_rd[SLOT_W-1:0] == r_bidx;
            end
            S_INST: begin
                slot_we = 1'b1;
                vld_we  = 1'b1;
                map_we  = 1'b1;
                clk_we  = 1'b1;
            end
            default: ;
        endcase
        // recency quotient: started once the slot entry is in hand
        if (r_state == S_SDATA) begin
            div_start = (slot_rd.last_t < r_now)
                        && ((r_now - slot_rd.last_t) < TIME_W'(1 << FRAC));
            div_dvs   = {1'b0, r_now - slot_rd.last_t} + DVS_W'(1);
        end
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            // drop a taken result, raise a new one when the emit step fires
            r_ov <= (r_ov & i_out_stall) | ((r_state == S_EMIT) & out_free);
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + MAP_AW'(1);
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd <= i_q_cmd;
                        r_res <= '{status: ST_IGNORE, was_loaded: 1'b0,
                                   slot: '0, evicted: '0};
                        r_state <= i_q_cmd.ok ? S_LOOK : S_EMIT;
                    end
                end
                S_LOOK: begin
                    r_now  <= now1;
                    r_vrow <= vld_rd;
                    r_idx  <= '0;
                    if (r_cmd.op == OP_PREWARM) begin
                        if (!map_rd[SLOT_W] && free_found) begin
                            r_slot  <= free_idx;
                            r_cnt1  <= 1'b0;
                            r_res   <= '{status: ST_PREWARM, was_loaded: 1'b0,
                                         slot: free_idx, evicted: '0};
                            r_state <= S_INST;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end else if (hit) begin
                        r_slot  <= hs;
                        r_res   <= '{status: ST_HIT, was_loaded: 1'b1,
                                     slot: hs, evicted: '0};
                        r_state <= S_HITWR;
                    end else if (free_found) begin
                        r_slot  <= free_idx;
                        r_cnt1  <= 1'b1;
                        r_res   <= '{status: ST_FREE, was_loaded: 1'b0,
                                     slot: free_idx, evicted: '0};
                        r_state <= S_INST;
                    end else begin
                        r_state <= S_SRD;
                    end
                end
                S_HITWR: r_state <= S_EMIT;
                S_SRD:   r_state <= S_SDATA;
                S_SDATA: begin
                    r_ent <= slot_rd;
                    if (slot_rd.last_t >= r_now) begin
                        r_r     <= REC_W'(1 << FRAC);
                        r_state <= S_FSET;
                    end else if ((r_now - slot_rd.last_t) >= TIME_W'(1 << FRAC)) begin
                        r_r     <= '0;
                        r_state <= S_FSET;
                    end else begin
                        r_state <= S_RDIV;
                    end
                end
                S_RDIV: begin
                    if (div_done) begin
                        r_r     <= div_q[REC_W-1:0];
                        r_state <= S_FSET;
                    end
                end
                S_FSET: begin
                    if (r_ent.cnt == '0) begin
                        r_f     <= '0;
                        r_state <= S_CMP;
                    end else if (r_now <= r_ent.load_t) begin
                        r_f     <= {r_ent.cnt, {FRAC{1'b0}}};
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_FDIV;
                    end
                end
                S_FDIV: begin
                    if (div_done) begin
                        r_f     <= div_q;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (take) begin
                        r_best <= score;
                        r_bidx <= r_idx;
                        r_bid  <= r_ent.id;
                    end
                    if (r_idx == r_cmd.last) begin
                        r_state <= S_EVMAP;
                    end else begin
                        r_idx   <= r_idx + SLOT_W'(1);
                        r_state <= S_SRD;
                    end
                end
                S_EVMAP: r_state <= S_EVCHK;
                S_EVCHK: begin
                    r_slot  <= r_bidx;
                    r_cnt1  <= 1'b1;
                    r_res   <= '{status: ST_EVICT, was_loaded: 1'b0,
                                 slot: r_bidx, evicted: r_bid};
                    r_state <= S_INST;
                end
                S_INST:  r_state <= S_EMIT;
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_stat.clearing = r_state == S_CLEAR;
    assign o_out_valid     = r_ov;
    assign o_result        = r_out;

`ifndef SYNTH
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_state == S_IDLE)
        else $error("queue popped outside idle");
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> r_idx <= r_cmd.last)
        else $error("scan index beyond slot count");
`endif
endmodule
